FILE: rtl/ovle_pkg.sv
// ----------------------------------------------------------------------------
// ovle_pkg: shared types and constants for the ordered value list engine
// Command codes, result status codes, sequencer states and list defaults.
// ----------------------------------------------------------------------------
package ovle_pkg;

  // default list capacity
  localparam int unsigned DEPTH = 16;

  // payload widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_DUMP_HEAD = 2'd2,
    CMD_DUMP_TAIL = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_RESP     = 3'd1,
    S_SRCH_RD  = 3'd2,
    S_SRCH_CMP = 3'd3,
    S_SHIFT_RD = 3'd4,
    S_SHIFT_WR = 3'd5,
    S_DUMP_RD  = 3'd6,
    S_DUMP_OUT = 3'd7
  } state_e;

endpackage

FILE: rtl/ordered_value_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_value_list_engine: ordered list of signed 32-bit values
// Append at tail, remove first match from head, dump from head or tail.
// Values live packed in a single-port-write, registered-read memory; one
// shared compare/read step runs per cycle under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: append or an empty list goes to its status word; remove reads
//   and compares each entry searched, then reads and writes down each entry
//   behind the match; a dump reads each word from the registered-read memory.
// Throughput: one command at a time; a new word is taken once the last
//   word of the previous command sits in the output register.
// Reset: the list is empty (count cleared); memory contents are not cleared.

module ordered_value_list_engine #(
  parameter int unsigned DEPTH = ovle_pkg::DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ovle_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [ovle_pkg::VALUE_W-1:0]  item_value_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ovle_pkg::VALUE_W-1:0]  out_value_o,
  output logic [ovle_pkg::STATUS_W-1:0]        status_o,
  output logic                                 last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = ovle_pkg::VALUE_W;

  // sequencer and list state
  ovle_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [VW-1:0]     key_q, key_d;
  logic              back_q, back_d;
  ovle_pkg::status_e resp_q, resp_d;

  // memory ports
  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VW-1:0] wr_data;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [VW-1:0]            out_value_q;
  ovle_pkg::status_e        out_status_q;
  logic                     out_last_q;
  logic                     out_load;
  logic [VW-1:0]            load_value;
  ovle_pkg::status_e        load_status;
  logic                     load_last;

  logic          accept;
  logic          out_free;
  logic [CW-1:0] idx_nx;
  logic          dump_last;

  assign in_stall_o = (state_q != ovle_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_nx     = CW'(idx_q) + CW'(1);
  assign dump_last  = back_q ? (idx_q == '0) : (idx_nx == count_q);

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    key_d       = key_q;
    back_d      = back_q;
    resp_d      = resp_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rd_data_q;
    out_load    = 1'b0;
    load_value  = '0;
    load_status = resp_q;
    load_last   = 1'b1;
    case (state_q)
      ovle_pkg::S_IDLE: begin
        if (accept) begin
          case (ovle_pkg::cmd_e'(cmd_i))
            ovle_pkg::CMD_APPEND: begin
              state_d = ovle_pkg::S_RESP;
              if (count_q == CW'(DEPTH)) begin
                resp_d = ovle_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                wr_data = item_value_i;
                count_d = count_q + CW'(1);
                resp_d  = ovle_pkg::ST_OK;
              end
            end
            ovle_pkg::CMD_REMOVE: begin
              if (count_q == '0) begin
                resp_d  = ovle_pkg::ST_EMPTY;
                state_d = ovle_pkg::S_RESP;
              end else begin
                key_d   = item_value_i;
                idx_d   = '0;
                state_d = ovle_pkg::S_SRCH_RD;
              end
            end
            default: begin
              // both dump directions
              if (count_q == '0) begin
                resp_d  = ovle_pkg::ST_EMPTY;
                state_d = ovle_pkg::S_RESP;
              end else begin
                back_d  = (cmd_i == ovle_pkg::CMD_DUMP_TAIL);
                idx_d   = (cmd_i == ovle_pkg::CMD_DUMP_TAIL)
                          ? AW'(count_q - CW'(1)) : '0;
                state_d = ovle_pkg::S_DUMP_RD;
              end
            end
          endcase
        end
      end
      ovle_pkg::S_RESP: begin
        // single word: status only
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ovle_pkg::S_IDLE;
        end
      end
      ovle_pkg::S_SRCH_RD: begin
        rd_en   = 1'b1;
        state_d = ovle_pkg::S_SRCH_CMP;
      end
      ovle_pkg::S_SRCH_CMP: begin
        if (rd_data_q == key_q) begin
          state_d = ovle_pkg::S_SHIFT_RD;
        end else if (idx_nx == count_q) begin
          resp_d  = ovle_pkg::ST_NOT_FOUND;
          state_d = ovle_pkg::S_RESP;
        end else begin
          idx_d   = idx_nx[AW-1:0];
          state_d = ovle_pkg::S_SRCH_RD;
        end
      end
      ovle_pkg::S_SHIFT_RD: begin
        // close the gap one entry at a time
        if (idx_nx >= count_q) begin
          count_d = count_q - CW'(1);
          resp_d  = ovle_pkg::ST_OK;
          state_d = ovle_pkg::S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_nx[AW-1:0];
          state_d = ovle_pkg::S_SHIFT_WR;
        end
      end
      ovle_pkg::S_SHIFT_WR: begin
        wr_en   = 1'b1;
        idx_d   = idx_nx[AW-1:0];
        state_d = ovle_pkg::S_SHIFT_RD;
      end
      ovle_pkg::S_DUMP_RD: begin
        rd_en   = 1'b1;
        state_d = ovle_pkg::S_DUMP_OUT;
      end
      ovle_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_value  = rd_data_q;
          load_status = ovle_pkg::ST_OK;
          load_last   = dump_last;
          if (dump_last) begin
            state_d = ovle_pkg::S_IDLE;
          end else begin
            idx_d   = back_q ? (idx_q - AW'(1)) : idx_nx[AW-1:0];
            state_d = ovle_pkg::S_DUMP_RD;
          end
        end
      end
      default: begin
        state_d = ovle_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ovle_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    back_q <= back_d;
    resp_q <= resp_d;
  end

  // list memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // output word register
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= load_value;
      out_status_q <= load_status;
      out_last_q   <= load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count above capacity");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ovle_pkg::ST_OK) |-> last_o && (out_value_o == '0))
    else $error("error word not final or carries a value");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ovle_pkg::S_IDLE))
    else $error("accepted word did not start a command");

  a_search_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ovle_pkg::S_SRCH_CMP) || (state_q == ovle_pkg::S_SRCH_RD)
    |-> (CW'(idx_q) < count_q))
    else $error("search index beyond list tail");

endmodule

FILE: bench/ovle_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ovle_list_checker: scoreboard for the ordered value list engine
// Watches both channels, keeps its own copy of the list, predicts the words
// each accepted command must produce, and compares every returned word in
// order. Hands back the number of failures and the words still outstanding.
// ----------------------------------------------------------------------------

module ovle_list_checker #(
  parameter int unsigned DEPTH = ovle_pkg::DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [ovle_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [ovle_pkg::VALUE_W-1:0]  item_value_i,
  // output channel
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [ovle_pkg::VALUE_W-1:0]  out_value_i,
  input  logic [ovle_pkg::STATUS_W-1:0]        status_i,
  input  logic                                 last_i,
  // verdict
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import ovle_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_e                   status;
    logic                      last;
  } list_word_t;

  // predicted list contents, head at index 0
  logic signed [VALUE_W-1:0] list_model[$];
  // words still owed by the block, oldest first
  list_word_t                owed_words[$];

  // work out the words one command produces and update the list copy
  task automatic predict_command(input cmd_e c, input logic signed [VALUE_W-1:0] v);
    int         hit;
    int         n;
    list_word_t w;
    hit = -1;
    n   = list_model.size();
    w   = '{value: '0, status: ST_OK, last: 1'b1};
    case (c)
      CMD_APPEND: begin
        if (n >= DEPTH) w.status = ST_FULL;
        else list_model.push_back(v);
        owed_words.push_back(w);
      end
      CMD_REMOVE: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
        end else begin
          // first match from the head only
          for (int k = 0; k < n; k++)
            if (hit < 0 && list_model[k] == v) hit = k;
          if (hit < 0) w.status = ST_NOT_FOUND;
          else list_model.delete(hit);
        end
        owed_words.push_back(w);
      end
      default: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
          owed_words.push_back(w);
        end else begin
          for (int k = 0; k < n; k++) begin
            w.value = (c == CMD_DUMP_HEAD) ? list_model[k] : list_model[n-1-k];
            w.last  = (k == n - 1);
            owed_words.push_back(w);
          end
        end
      end
    endcase
  endtask

  // compare one returned word with the oldest prediction
  task automatic check_word();
    list_word_t w;
    if (owed_words.size() == 0) begin
      $display("%0t: unexpected word: expected none, got value %0d status %0d last %0b",
               $realtime, out_value_i, status_i, last_i);
      fail_count_o++;
    end else begin
      w = owed_words.pop_front();
      if (out_value_i !== w.value) begin
        $display("%0t: value mismatch: expected %0d, got %0d",
                 $realtime, w.value, out_value_i);
        fail_count_o++;
      end
      if (status_i !== w.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $realtime, w.status, status_i);
        fail_count_o++;
      end
      if (last_i !== w.last) begin
        $display("%0t: last mismatch: expected %0b, got %0b",
                 $realtime, w.last, last_i);
        fail_count_o++;
      end
    end
  endtask

  // sample both channels on the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_model.delete();
      owed_words.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_command(cmd_e'(cmd_i), item_value_i);
      if (out_valid_i && !out_stall_i) check_word();
      pending_o <= owed_words.size();
    end
  end

  initial fail_count_o = 0;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level testbench for the ordered value list engine
// Drives a directed opening (empty list, extremes, duplicates, full list)
// and then random fill and drain sequences over a small value pool, with
// random gaps and stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------

module tb;
  import ovle_pkg::*;

  localparam int RANDOM_ITEMS = 345;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i;
  logic signed [31:0]    item_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [31:0]    out_value_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  last_o;
  logic                  idle_on;
  int                    fail_count;
  int                    pending;
  logic [31:0]           value_pool[8];

  ordered_value_list_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  ovle_list_checker list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (cmd_i),
    .item_value_i (item_value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_i  (out_value_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver stalls at random while idling is enabled
  initial out_stall_i = 1'b0;
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(0, 99) < 27);
  end

  // hand one command word to the block, with an optional random gap first
  task automatic send_word(input cmd_e c, input logic [31:0] v);
    while (idle_on && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    item_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold the sender until every owed word has come back
  task automatic drain_list_engine();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // new random value pool, with the extremes now and then
  task automatic refresh_pool();
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 9))
        0:       value_pool[k] = 32'h8000_0000;
        1:       value_pool[k] = 32'h7fff_ffff;
        2:       value_pool[k] = 32'h0000_0000;
        default: value_pool[k] = $urandom;
      endcase
    end
  endtask

  // stimulus
  initial begin
    int          r;
    int          mode_left;
    logic        fill_mode;
    logic [31:0] v;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_APPEND;
    item_value_i = '0;
    idle_on      = 1'b1;
    fill_mode    = 1'b1;
    mode_left    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: both dumps and a remove
    send_word(CMD_DUMP_HEAD, 32'h0);
    send_word(CMD_DUMP_TAIL, 32'hffff_ffff);
    send_word(CMD_REMOVE, 32'h8000_0000);
    // extremes and a duplicate
    send_word(CMD_APPEND, 32'h8000_0000);
    send_word(CMD_APPEND, 32'h7fff_ffff);
    send_word(CMD_APPEND, 32'hffff_ffff);
    send_word(CMD_APPEND, 32'h0000_0000);
    send_word(CMD_APPEND, 32'hffff_ffff);
    send_word(CMD_DUMP_HEAD, 32'h5555_5555);
    send_word(CMD_DUMP_TAIL, 32'haaaa_aaaa);
    // miss, then first of two duplicates
    send_word(CMD_REMOVE, 32'd5);
    send_word(CMD_REMOVE, 32'hffff_ffff);
    send_word(CMD_DUMP_HEAD, 32'h0);
    // fill to capacity, then one append too many
    for (int k = 0; k < DEPTH - 4; k++) send_word(CMD_APPEND, $urandom);
    send_word(CMD_APPEND, 32'h1234_5678);
    send_word(CMD_DUMP_TAIL, 32'h0);
    drain_list_engine();

    // random fill and drain sequences over a value pool
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        fill_mode = ~fill_mode;
        mode_left = $urandom_range(10, 40);
        refresh_pool();
      end
      mode_left--;
      // long stretch with no gaps or stalls
      if (n == 150) idle_on <= 1'b0;
      if (n == 230) idle_on <= 1'b1;
      if (n == 200) drain_list_engine();
      v = ($urandom_range(0, 9) < 8) ? value_pool[$urandom_range(0, 7)] : $urandom;
      r = $urandom_range(0, 99);
      if (r < 12) send_word(CMD_DUMP_HEAD, v);
      else if (r < 24) send_word(CMD_DUMP_TAIL, v);
      else if (r < (fill_mode ? 70 : 40)) send_word(CMD_APPEND, v);
      else send_word(CMD_REMOVE, v);
    end

    // let everything come back, then allow for a late stray word
    drain_list_engine();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
